>>> rtl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, constants and arithmetic helpers for the pressure and
// temperature compensation pipeline.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int RawW    = 20;
    localparam int WordW   = 32;
    localparam int CfgW    = 64;
    localparam int DivW    = 32;

    typedef enum logic [1:0] {
        REG_TEMP_CAL     = 2'd0,
        REG_PRESS_LOW    = 2'd1,
        REG_PRESS_HIGH   = 2'd2,
        REG_PRESS_LAST   = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [RawW-1:0] raw_temperature;
        logic [RawW-1:0] raw_pressure;
    } sample_t;

    typedef struct packed {
        logic signed [WordW-1:0] temperature_centi;
        logic [WordW-1:0]        pressure_pa;
        logic                    pressure_valid;
    } result_t;

    // Calibration words, extended to 32 bits (t1 and p1 zero extended, the rest sign extended)
    typedef struct packed {
        logic [WordW-1:0] t1, t2, t3;
        logic [WordW-1:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    } calib_t;

    // Arithmetic shift right on a 32-bit word
    function automatic logic [WordW-1:0] asr(input logic [WordW-1:0] v,
                                             input int unsigned s);
        logic signed [WordW-1:0] t;
        t = signed'(v);
        return WordW'(unsigned'(t >>> s));
    endfunction

    function automatic logic [WordW-1:0] sx16(input logic [15:0] w);
        return {{16{w[15]}}, w};
    endfunction

endpackage

>>> rtl/ptc_divider.sv
// ----------------------------------------------------------------------------
// ptc_divider
// Pipelined restoring divider: one quotient bit per stage, 32 stages.
// Carries a side-band word alongside each quotient.
// ----------------------------------------------------------------------------
module ptc_divider
    import ptc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [DivW-1:0]       dividend,
    input  logic [DivW-1:0]       divisor,
    input  logic [DivW:0]         side_in,
    output logic                  out_valid,
    output logic [DivW-1:0]       quotient,
    output logic [DivW:0]         side_out
);

    logic [DivW-1:0] valid_reg;
    logic [DivW-1:0] rem_reg [DivW];
    logic [DivW-1:0] quo_reg [DivW];
    logic [DivW-1:0] den_reg [DivW];
    logic [DivW:0]   side_reg [DivW];

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[DivW-2:0], in_valid};
        end
    end

    // One quotient bit per stage, MSB first
    for (genvar g = 0; g < DivW; g++)
    begin : g_stage
        logic [DivW-1:0] rem_in, quo_in, den_in;
        logic [DivW:0]   side_i;
        logic [DivW:0]   trial;
        logic [DivW:0]   diff;

        if (g == 0)
        begin : g_first
            assign rem_in = '0;
            assign quo_in = dividend;
            assign den_in = divisor;
            assign side_i = side_in;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[g-1];
            assign quo_in = quo_reg[g-1];
            assign den_in = den_reg[g-1];
            assign side_i = side_reg[g-1];
        end

        assign trial = {rem_in, quo_in[DivW-1]};
        assign diff  = trial - {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            den_reg[g]  <= den_in;
            side_reg[g] <= side_i;
            if (!diff[DivW])
            begin
                rem_reg[g] <= diff[DivW-1:0];
                quo_reg[g] <= {quo_in[DivW-2:0], 1'b1};
            end
            else
            begin
                rem_reg[g] <= trial[DivW-1:0];
                quo_reg[g] <= {quo_in[DivW-2:0], 1'b0};
            end
        end
    end

    assign out_valid = valid_reg[DivW-1];
    assign quotient  = quo_reg[DivW-1];
    assign side_out  = side_reg[DivW-1];

endmodule

>>> rtl/ptc_front.sv
// ----------------------------------------------------------------------------
// ptc_front
// Temperature path and pressure pre-divide terms, cut into register stages.
// Produces the dividend, divisor and the compensated temperature.
// ----------------------------------------------------------------------------
module ptc_front
    import ptc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  sample_t          sample,
    input  calib_t           cal,
    output logic             out_valid,
    output logic [WordW-1:0] dividend,
    output logic [WordW-1:0] divisor,
    output logic             pre_double,
    output logic [WordW-1:0] temp_out
);

    localparam logic [WordW-1:0] Off64k = 32'd64000;
    localparam logic [WordW-1:0] Half   = 32'd32768;
    localparam logic [WordW-1:0] Full   = 32'd1048576;
    localparam logic [WordW-1:0] K3125  = 32'd3125;

    logic [7:0] v_reg;

    // stage 1
    logic [WordW-1:0] s1_x_reg, s1_d2_reg, s1_adcp_reg;
    // stage 2
    logic [WordW-1:0] s2_a_reg, s2_dd_reg, s2_adcp_reg;
    // stage 3
    logic [WordW-1:0] s3_a_reg, s3_b_reg, s3_adcp_reg;
    // stage 4
    logic [WordW-1:0] s4_fine_reg, s4_adcp_reg;
    // stage 5
    logic [WordW-1:0] s5_t5_reg, s5_qq_reg, s5_ap5_reg, s5_pa2_reg;
    logic [WordW-1:0] s5_adcp_reg;
    // stage 6
    logic [WordW-1:0] s6_temp_reg, s6_b6_reg, s6_p3q_reg, s6_ap5_reg, s6_p2a_reg;
    logic [WordW-1:0] s6_adcp_reg;
    // stage 7
    logic [WordW-1:0] s7_temp_reg, s7_b_reg, s7_a_reg, s7_adcp_reg;
    // stage 8
    logic [WordW-1:0] s8_temp_reg, s8_num_reg, s8_div_reg;

    logic [WordW-1:0] adct, adcp;
    assign adct = WordW'(sample.raw_temperature);
    assign adcp = WordW'(sample.raw_pressure);

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[6:0], in_valid};
        end
    end

    // Stage logic
    logic [WordW-1:0] pa, q;
    logic [WordW-1:0] b7, a7, num7, divs7;
    always_comb
    begin
        pa    = asr(s4_fine_reg, 1) - Off64k;
        q     = asr(pa, 2);
        b7    = asr(s6_b6_reg + (s6_ap5_reg << 1), 2) + (cal.p4 << 16);
        a7    = asr(asr(s6_p3q_reg, 3) + asr(s6_p2a_reg, 1), 18);
        num7  = ((Full - s7_adcp_reg) - asr(s7_b_reg, 12));
        divs7 = Half + s7_a_reg;
    end

    always_ff @(posedge clk)
    begin
        s1_x_reg    <= (adct >> 3) - (cal.t1 << 1);
        s1_d2_reg   <= (adct >> 4) - cal.t1;
        s1_adcp_reg <= adcp;

        s2_a_reg    <= s1_x_reg * cal.t2;
        s2_dd_reg   <= s1_d2_reg * s1_d2_reg;
        s2_adcp_reg <= s1_adcp_reg;

        s3_a_reg    <= asr(s2_a_reg, 11);
        s3_b_reg    <= asr(s2_dd_reg, 12) * cal.t3;
        s3_adcp_reg <= s2_adcp_reg;

        s4_fine_reg <= s3_a_reg + asr(s3_b_reg, 14);
        s4_adcp_reg <= s3_adcp_reg;

        s5_t5_reg   <= s4_fine_reg * 32'd5 + 32'd128;
        s5_qq_reg   <= q * q;
        s5_ap5_reg  <= pa * cal.p5;
        s5_pa2_reg  <= cal.p2 * pa;
        s5_adcp_reg <= s4_adcp_reg;

        s6_temp_reg <= asr(s5_t5_reg, 8);
        s6_b6_reg   <= asr(s5_qq_reg, 11) * cal.p6;
        s6_p3q_reg  <= cal.p3 * asr(s5_qq_reg, 13);
        s6_ap5_reg  <= s5_ap5_reg;
        s6_p2a_reg  <= s5_pa2_reg;
        s6_adcp_reg <= s5_adcp_reg;

        s7_temp_reg <= s6_temp_reg;
        s7_b_reg    <= b7;
        s7_a_reg    <= a7;
        s7_adcp_reg <= s6_adcp_reg;

        s8_temp_reg <= s7_temp_reg;
        s8_num_reg  <= num7 * K3125;
        s8_div_reg  <= divs7 * cal.p1;
    end

    logic [WordW-1:0] dv;
    assign dv         = asr(s8_div_reg, 15);
    assign pre_double = s8_num_reg[WordW-1];
    assign dividend   = pre_double ? s8_num_reg : (s8_num_reg << 1);
    assign divisor    = dv;
    assign temp_out   = s8_temp_reg;
    assign out_valid  = v_reg[7];

endmodule

>>> rtl/ptc_back.sv
// ----------------------------------------------------------------------------
// ptc_back
// Post-divide pressure correction with p7, p8, p9 in register stages.
// ----------------------------------------------------------------------------
module ptc_back
    import ptc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [WordW-1:0] quotient,
    input  logic             pre_double,
    input  logic             zero_div,
    input  logic [WordW-1:0] temp_in,
    input  calib_t           cal,
    output logic             out_valid,
    output result_t          result
);

    logic [3:0] v_reg;
    logic [WordW-1:0] s1_p_reg, s1_sq_reg, s1_b_reg, s1_t_reg;
    logic [WordW-1:0] s2_p_reg, s2_a_reg, s2_b_reg, s2_t_reg;
    logic [WordW-1:0] s3_p_reg, s3_t_reg;
    logic [WordW-1:0] s4_p_reg, s4_t_reg;
    logic [3:0]       z_reg;

    logic [WordW-1:0] p0, p3;
    assign p0 = pre_double ? (quotient << 1) : quotient;
    assign p3 = p0 >> 3;

    // Advance valid and divisor-zero flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
            z_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[2:0], in_valid};
            z_reg <= {z_reg[2:0], zero_div};
        end
    end

    always_ff @(posedge clk)
    begin
        s1_p_reg  <= p0;
        s1_sq_reg <= p3 * p3;
        s1_b_reg  <= (p0 >> 2) * cal.p8;
        s1_t_reg  <= temp_in;

        s2_p_reg  <= s1_p_reg;
        s2_a_reg  <= cal.p9 * (s1_sq_reg >> 13);
        s2_b_reg  <= asr(s1_b_reg, 13);
        s2_t_reg  <= s1_t_reg;

        s3_p_reg  <= s2_p_reg + asr(asr(s2_a_reg, 12) + s2_b_reg + cal.p7, 4);
        s3_t_reg  <= s2_t_reg;

        s4_p_reg  <= z_reg[2] ? '0 : s3_p_reg;
        s4_t_reg  <= s3_t_reg;
    end

    assign out_valid                = v_reg[3];
    assign result.temperature_centi = signed'(s4_t_reg);
    assign result.pressure_pa       = s4_p_reg;
    assign result.pressure_valid    = ~z_reg[3];

endmodule

>>> rtl/pressure_temp_compensation.sv
// ----------------------------------------------------------------------------
// pressure_temp_compensation
// Integer temperature and pressure compensation of raw 20-bit conversions.
// ----------------------------------------------------------------------------
// A new sample pair is taken every cycle that start is high; busy stays low.
// Each sample gives one result beat, marked by done, after eight
// stages of temperature and pre-divide arithmetic, a 32-stage divider that
// yields one quotient bit per stage, four correction stages and one output
// register. Results cannot be held off, so take them in the done cycle.
// A divisor of zero gives pressure 0 with pressure_valid low.
module pressure_temp_compensation
    import ptc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  sample_t         sample,
    output logic            done,
    output result_t         result,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [CfgW-1:0] cfg_data
);

    logic [47:0] tcal_reg;
    logic [63:0] plow_reg, phigh_reg;
    logic [15:0] plast_reg;
    calib_t      cal;

    // Hold calibration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcal_reg  <= '0;
            plow_reg  <= '0;
            phigh_reg <= '0;
            plast_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_TEMP_CAL:   tcal_reg  <= cfg_data[47:0];
                REG_PRESS_LOW:  plow_reg  <= cfg_data;
                REG_PRESS_HIGH: phigh_reg <= cfg_data;
                REG_PRESS_LAST: plast_reg <= cfg_data[15:0];
                default:        ;
            endcase
        end
    end

    // Unpack calibration words
    always_comb
    begin
        cal.t1 = {16'd0, tcal_reg[15:0]};
        cal.t2 = sx16(tcal_reg[31:16]);
        cal.t3 = sx16(tcal_reg[47:32]);
        cal.p1 = {16'd0, plow_reg[15:0]};
        cal.p2 = sx16(plow_reg[31:16]);
        cal.p3 = sx16(plow_reg[47:32]);
        cal.p4 = sx16(plow_reg[63:48]);
        cal.p5 = sx16(phigh_reg[15:0]);
        cal.p6 = sx16(phigh_reg[31:16]);
        cal.p7 = sx16(phigh_reg[47:32]);
        cal.p8 = sx16(phigh_reg[63:48]);
        cal.p9 = sx16(plast_reg);
    end

    assign busy = 1'b0;

    logic             f_valid, f_pre;
    logic [WordW-1:0] f_dividend, f_divisor, f_temp;

    ptc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start),
        .sample     (sample),
        .cal        (cal),
        .out_valid  (f_valid),
        .dividend   (f_dividend),
        .divisor    (f_divisor),
        .pre_double (f_pre),
        .temp_out   (f_temp)
    );

    logic             d_valid, zero;
    logic [WordW-1:0] d_quo;
    logic [DivW:0]    d_side;
    logic [DivW:0]    side_in;
    logic [WordW-1:0] safe_div;

    // Force a nonzero divisor when zero; the result is masked later
    assign zero     = (f_divisor == '0);
    assign safe_div = zero ? 32'd1 : f_divisor;
    assign side_in  = {f_pre, f_temp};

    logic [DivW:0]  zside_unused;
    logic [DivW-1:0] zero_pipe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_pipe_reg <= '0;
        end
        else
        begin
            zero_pipe_reg <= {zero_pipe_reg[DivW-2:0], zero};
        end
    end

    ptc_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .dividend  (f_dividend),
        .divisor   (safe_div),
        .side_in   (side_in),
        .out_valid (d_valid),
        .quotient  (d_quo),
        .side_out  (d_side)
    );
    assign zside_unused = d_side;

    logic    b_valid;
    result_t b_result;

    ptc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (d_valid),
        .quotient   (d_quo),
        .pre_double (zside_unused[DivW]),
        .zero_div   (zero_pipe_reg[DivW-1]),
        .temp_in    (zside_unused[DivW-1:0]),
        .cal        (cal),
        .out_valid  (b_valid),
        .result     (b_result)
    );

    logic    done_reg;
    result_t result_reg;

    // Register the result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= b_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= b_result;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> rtl/ptc_checker.sv
// ----------------------------------------------------------------------------
// ptc_checker
// Port-level checks on the compensation block, bound to the top level.
// ----------------------------------------------------------------------------
module ptc_checker
    import ptc_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    // Never stall the sender
    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy asserted");

    // Each beat leaves after fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##45 done)
        else $error("result beat missing");

    // No beat without a sample
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 45))
        else $error("unexpected result beat");

    // Invalid pressure reads zero
    a_zero_p: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.pressure_valid |-> result.pressure_pa == '0)
        else $error("pressure nonzero while invalid");

endmodule

bind pressure_temp_compensation ptc_checker u_ptc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
